@@ hdl/ptc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_pkg
// Shared types, codes and helpers for the Perl token classifier.
// ----------------------------------------------------------------------------
package ptc_pkg;

  localparam int unsigned CharW       = 16;
  localparam int unsigned PosW        = 32;
  localparam int unsigned QueueDepth  = 4;
  localparam int unsigned QueuePtrW   = $clog2(QueueDepth);
  localparam int unsigned InDataW     = 16;
  localparam int unsigned OutDataW    = 72;

  // Character codes the lexer looks at
  localparam logic [CharW-1:0] ChTab       = 16'h0009;
  localparam logic [CharW-1:0] ChNewline   = 16'h000A;
  localparam logic [CharW-1:0] ChSpace     = 16'h0020;
  localparam logic [CharW-1:0] ChDquote    = 16'h0022;
  localparam logic [CharW-1:0] ChHash      = 16'h0023;
  localparam logic [CharW-1:0] ChDollar    = 16'h0024;
  localparam logic [CharW-1:0] ChPercent   = 16'h0025;
  localparam logic [CharW-1:0] ChSquote    = 16'h0027;
  localparam logic [CharW-1:0] ChLparen    = 16'h0028;
  localparam logic [CharW-1:0] ChMinus     = 16'h002D;
  localparam logic [CharW-1:0] ChColon     = 16'h003A;
  localparam logic [CharW-1:0] ChGreater   = 16'h003E;
  localparam logic [CharW-1:0] ChAt        = 16'h0040;
  localparam logic [CharW-1:0] ChBackslash = 16'h005C;

  typedef enum logic [3:0] {
    ModeNormal     = 4'd0,
    ModeDq         = 4'd1,
    ModeDqEsc      = 4'd2,
    ModeComment    = 4'd3,
    ModeCommentEsc = 4'd4,
    ModeNumber     = 4'd5,
    ModeSq         = 4'd6,
    ModeSqEsc      = 4'd7,
    ModeVar        = 4'd8,
    ModeVarName    = 4'd9,
    ModeWord       = 4'd10
  } mode_e;

  typedef enum logic [2:0] {
    ClsGap      = 3'd0,
    ClsComment  = 3'd1,
    ClsNumber   = 3'd2,
    ClsOperator = 3'd3,
    ClsString   = 3'd4,
    ClsVariable = 3'd5,
    ClsCall     = 3'd6,
    ClsBare     = 3'd7
  } class_e;

  // Sub-span selector in the back end
  typedef enum logic [1:0] {
    StepFirst = 2'd0,
    StepGap   = 2'd1,
    StepOper  = 2'd2
  } step_e;

  // Spans caused by one item: a first span from the token start, an optional
  // empty gap at the current position and an optional one-character operator.
  typedef struct packed {
    class_e            first_cls;
    logic              first_to_next;
    logic              partial;
    logic              has_gap;
    logic              has_oper;
    logic [PosW-1:0]   begin_pos;
    logic [PosW-1:0]   cur_pos;
    logic [PosW-1:0]   next_pos;
  } span_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic logic is_word(input logic [CharW-1:0] c);
    logic res;
    res = 1'b0;
    if (c >= 16'h0080) res = 1'b1;
    else if (c >= 16'h0030 && c <= 16'h0039) res = 1'b1;
    else if (c >= 16'h0041 && c <= 16'h005A) res = 1'b1;
    else if (c >= 16'h0061 && c <= 16'h007A) res = 1'b1;
    else if (c == 16'h005E || c == 16'h005F || c == 16'h007C || c == 16'h007E) res = 1'b1;
    return res;
  endfunction

endpackage

@@ hdl/ptc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_front
// Lexer state machine: takes one code unit a beat and builds the span entry.
// ----------------------------------------------------------------------------
module ptc_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic [ptc_pkg::CharW-1:0] char_code_i,
  input  logic                      end_of_text_i,
  input  ptc_pkg::queue_status_t    queue_status_i,
  output logic                      in_ready_o,
  output logic                      push_o,
  output ptc_pkg::span_entry_t      push_entry_o
);
  import ptc_pkg::*;

  mode_e           mode_q, mode_d;
  class_e          cls_q, cls_d;
  logic [PosW-1:0] begin_q, begin_d;
  logic [PosW-1:0] pos_q, pos_d;

  logic            fire;
  logic [PosW-1:0] next_pos;
  logic            ch_ws, ch_op, ch_word;
  mode_e           start_mode;
  class_e          start_cls;
  logic            close_again;
  span_entry_t     entry;

  assign in_ready_o = !queue_status_i.full;
  assign fire       = in_valid_i && in_ready_o;
  assign next_pos   = pos_q + 1'b1;
  assign ch_word    = is_word(char_code_i);
  assign ch_ws      = (char_code_i == ChTab) || (char_code_i == ChSpace) ||
                      (char_code_i == ChNewline);

  // Classify the token a character opens in the normal mode
  always_comb begin
    start_mode = ModeNormal;
    start_cls  = ClsGap;
    ch_op      = 1'b0;
    if (char_code_i == ChDquote) begin
      start_mode = ModeDq;
      start_cls  = ClsString;
    end else if (char_code_i == ChSquote) begin
      start_mode = ModeSq;
      start_cls  = ClsString;
    end else if (char_code_i == ChHash) begin
      start_mode = ModeComment;
      start_cls  = ClsComment;
    end else if (char_code_i == ChDollar || char_code_i == ChPercent ||
                 char_code_i == ChAt || char_code_i == ChGreater) begin
      start_mode = ModeVar;
      start_cls  = ClsVariable;
    end else if (char_code_i >= 16'h0030 && char_code_i <= 16'h0039) begin
      start_mode = ModeNumber;
      start_cls  = ClsNumber;
    end else if (ch_word) begin
      start_mode = ModeWord;
      start_cls  = ClsBare;
    end else begin
      ch_op = 1'b1;
    end
  end

  // Next state and span entry for the beat on the input
  always_comb begin
    mode_d      = mode_q;
    cls_d       = cls_q;
    begin_d     = begin_q;
    pos_d       = next_pos;
    close_again = 1'b0;
    push_o      = 1'b0;

    entry               = '0;
    entry.first_cls     = cls_q;
    entry.begin_pos     = begin_q;
    entry.cur_pos       = pos_q;
    entry.next_pos      = next_pos;

    if (end_of_text_i) begin
      // Flush the open token and restart the text
      push_o        = 1'b1;
      entry.partial = 1'b1;
      mode_d        = ModeNormal;
      cls_d         = ClsGap;
      begin_d       = '0;
      pos_d         = '0;
    end else begin
      case (mode_q)
        ModeDq, ModeSq: begin
          if ((mode_q == ModeDq && char_code_i == ChDquote) ||
              (mode_q == ModeSq && char_code_i == ChSquote)) begin
            push_o              = 1'b1;
            entry.first_cls     = ClsString;
            entry.first_to_next = 1'b1;
            mode_d              = ModeNormal;
            cls_d               = ClsGap;
            begin_d             = next_pos;
          end else if (char_code_i == ChBackslash) begin
            mode_d = (mode_q == ModeDq) ? ModeDqEsc : ModeSqEsc;
          end
        end
        ModeDqEsc:      mode_d = ModeDq;
        ModeSqEsc:      mode_d = ModeSq;
        ModeCommentEsc: mode_d = ModeComment;
        ModeComment: begin
          if (char_code_i == ChNewline) begin
            close_again     = 1'b1;
            entry.first_cls = ClsComment;
          end else if (char_code_i == ChBackslash) begin
            mode_d = ModeCommentEsc;
          end
        end
        ModeNumber: begin
          if (!ch_word) begin
            close_again     = 1'b1;
            entry.first_cls = ClsNumber;
          end
        end
        ModeVar: begin
          if (ch_word) begin
            mode_d = ModeVarName;
          end else begin
            close_again     = 1'b1;
            entry.first_cls = ClsVariable;
          end
        end
        ModeVarName: begin
          if (!ch_word) begin
            close_again     = 1'b1;
            entry.first_cls = ClsVariable;
          end
        end
        ModeWord: begin
          if (char_code_i == ChMinus || char_code_i == ChColon ||
              char_code_i == ChLparen) begin
            close_again     = 1'b1;
            entry.first_cls = ClsCall;
          end else if (!ch_word) begin
            close_again     = 1'b1;
            entry.first_cls = ClsBare;
          end
        end
        default: begin
          // Normal mode: a non-blank character ends the gap
          if (!ch_ws) begin
            push_o          = 1'b1;
            entry.first_cls = ClsGap;
            entry.has_oper  = ch_op;
            mode_d          = ch_op ? ModeNormal : start_mode;
            cls_d           = ch_op ? ClsGap : start_cls;
            begin_d         = ch_op ? next_pos : pos_q;
          end else begin
            mode_d = ModeNormal;
          end
        end
      endcase

      // Close at the current position, then take the character again
      if (close_again) begin
        push_o         = 1'b1;
        entry.has_gap  = !ch_ws;
        entry.has_oper = !ch_ws && ch_op;
        if (ch_ws) begin
          mode_d  = ModeNormal;
          cls_d   = ClsGap;
          begin_d = pos_q;
        end else begin
          mode_d  = ch_op ? ModeNormal : start_mode;
          cls_d   = ch_op ? ClsGap : start_cls;
          begin_d = ch_op ? next_pos : pos_q;
        end
      end
    end
    push_o       = push_o && fire;
    push_entry_o = entry;
  end

  // Hold lexer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ModeNormal;
      cls_q   <= ClsGap;
      begin_q <= '0;
      pos_q   <= '0;
    end else if (fire) begin
      mode_q  <= mode_d;
      cls_q   <= cls_d;
      begin_q <= begin_d;
      pos_q   <= pos_d;
    end
  end

endmodule

@@ hdl/ptc_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_queue
// Small FIFO of span entries between the lexer and the span serialiser.
// ----------------------------------------------------------------------------
module ptc_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  ptc_pkg::span_entry_t   push_entry_i,
  input  logic                   pop_i,
  output ptc_pkg::span_entry_t   head_entry_o,
  output ptc_pkg::queue_status_t status_o
);
  import ptc_pkg::*;

  span_entry_t          mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueuePtrW:0]   count_q, count_d;

  assign status_o.full  = (count_q == (QueuePtrW+1)'(QueueDepth));
  assign status_o.empty = (count_q == '0);
  assign head_entry_o   = mem_q[rd_ptr_q];

  // Track fill level
  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) count_d = count_q + 1'b1;
    else if (!push_i && pop_i) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (pop_i)  rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q <= count_d;
    end
  end

  // Store entries
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_entry_i;
  end

endmodule

@@ hdl/ptc_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptc_back
// Span serialiser: holds one entry and sends its spans one beat at a time.
// ----------------------------------------------------------------------------
module ptc_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ptc_pkg::span_entry_t         head_entry_i,
  input  ptc_pkg::queue_status_t       queue_status_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [ptc_pkg::OutDataW-1:0] out_data_o,
  output logic                         out_partial_o,
  output logic                         out_last_o
);
  import ptc_pkg::*;

  logic        cur_valid_q;
  span_entry_t cur_q;
  step_e       step_q, step_d;

  class_e          span_cls;
  logic [PosW-1:0] span_start, span_end;
  logic            fire, load;

  // Select the span for the current step
  always_comb begin
    span_cls      = cur_q.first_cls;
    span_start    = cur_q.begin_pos;
    span_end      = cur_q.first_to_next ? cur_q.next_pos : cur_q.cur_pos;
    out_partial_o = cur_q.partial;
    out_last_o    = !cur_q.has_gap && !cur_q.has_oper;
    step_d        = cur_q.has_gap ? StepGap : StepOper;
    case (step_q)
      StepGap: begin
        span_cls      = ClsGap;
        span_start    = cur_q.cur_pos;
        span_end      = cur_q.cur_pos;
        out_partial_o = 1'b0;
        out_last_o    = !cur_q.has_oper;
        step_d        = StepOper;
      end
      StepOper: begin
        span_cls      = ClsOperator;
        span_start    = cur_q.cur_pos;
        span_end      = cur_q.next_pos;
        out_partial_o = 1'b0;
        out_last_o    = 1'b1;
        step_d        = StepOper;
      end
      default: ;
    endcase
  end

  assign out_valid_o = cur_valid_q;
  assign out_data_o  = {5'b0, span_end, span_start, span_cls};
  assign fire        = cur_valid_q && out_ready_i;
  assign load        = !cur_valid_q || (fire && out_last_o);
  assign pop_o       = load && !queue_status_i.empty;

  // Advance through the entry, refill from the queue after its last span
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      step_q      <= StepFirst;
    end else if (load) begin
      cur_valid_q <= !queue_status_i.empty;
      step_q      <= StepFirst;
    end else if (fire) begin
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= head_entry_i;
  end

endmodule

@@ hdl/perl_token_classifier.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// perl_token_classifier
// Syntax span classifier for Perl text, one UTF-16 code unit per beat.
// ----------------------------------------------------------------------------
// Input stream: s_axis_tdata[15:0] carries a code unit, s_axis_tuser marks
// end of text, which flushes the open token as a partial span and restarts
// positions at zero. Output stream: each beat is one span (class, start,
// end); m_axis_tuser flags a partial span, m_axis_tlast marks the last span
// caused by one input beat. A beat can cause zero to three spans.
// A span is written to the queue, then loaded into the serialiser, and is
// offered from there. Throughput: one input beat per cycle while the output
// keeps pace; the output side sends one span per cycle while the receiver
// is ready, so the span serialiser sets the long-run rate. A four-entry queue
// decouples the lexer from the serialiser, so input is taken while spans wait.
// When the receiver stalls, the queue fills and s_axis_tready drops.
// Reset returns the lexer to the normal mode at position zero and empties
// the queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
module perl_token_classifier (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [ptc_pkg::InDataW-1:0]  s_axis_tdata,  // [15:0] char_code
  input  logic                         s_axis_tuser,  // [0] end_of_text
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [ptc_pkg::OutDataW-1:0] m_axis_tdata,  // [2:0] span_class,
                                                      // [34:3] span_start,
                                                      // [66:35] span_end, rest 0
  output logic                         m_axis_tuser,  // [0] span_partial
  output logic                         m_axis_tlast   // last_of_run
);
  import ptc_pkg::*;

  logic          push, pop;
  span_entry_t   push_entry, head_entry;
  queue_status_t queue_status;

  ptc_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .char_code_i    (s_axis_tdata[CharW-1:0]),
    .end_of_text_i  (s_axis_tuser),
    .queue_status_i (queue_status),
    .in_ready_o     (s_axis_tready),
    .push_o         (push),
    .push_entry_o   (push_entry)
  );

  ptc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .pop_i        (pop),
    .head_entry_o (head_entry),
    .status_o     (queue_status)
  );

  ptc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_entry_i   (head_entry),
    .queue_status_i (queue_status),
    .pop_o          (pop),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_data_o     (m_axis_tdata),
    .out_partial_o  (m_axis_tuser),
    .out_last_o     (m_axis_tlast)
  );

endmodule

@@ tb/tb_perl_token_classifier.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_perl_token_classifier
// Self-checking bench for the Perl token classifier. Streams code units in
// with random gaps and stalls the span output at random. A scoreboard class
// keeps its own lexer state, predicts the spans for every accepted beat and
// checks each span beat, in order, field by field.
// ----------------------------------------------------------------------------
module tb_perl_token_classifier;
  import ptc_pkg::*;

  localparam int unsigned CyclesLimit = 300000;
  localparam int unsigned TextUnits   = 210;

  // Bounds of the word character classes
  localparam logic [CharW-1:0] ChDigit0     = 16'h0030;
  localparam logic [CharW-1:0] ChDigit9     = 16'h0039;
  localparam logic [CharW-1:0] ChUpperA     = 16'h0041;
  localparam logic [CharW-1:0] ChUpperZ     = 16'h005A;
  localparam logic [CharW-1:0] ChCaret      = 16'h005E;
  localparam logic [CharW-1:0] ChUnderscore = 16'h005F;
  localparam logic [CharW-1:0] ChLowerA     = 16'h0061;
  localparam logic [CharW-1:0] ChLowerZ     = 16'h007A;
  localparam logic [CharW-1:0] ChBar        = 16'h007C;
  localparam logic [CharW-1:0] ChTilde      = 16'h007E;
  localparam logic [CharW-1:0] ChNonAscii   = 16'h0080;

  typedef struct {
    class_e          cls;
    logic [PosW-1:0] from_pos;
    logic [PosW-1:0] to_pos;
    logic            partial;
    logic            last;
  } span_t;

  // --------------------------------------------------------------------------
  // Scoreboard: own lexer state and the queue of spans still to arrive
  // --------------------------------------------------------------------------
  class span_scoreboard;
    mode_e           mode;
    class_e          open_cls;
    logic [PosW-1:0] tok_begin;
    logic [PosW-1:0] pos;
    span_t           expected_spans[$];
    span_t           run_spans[$];
    int              errors;
    int              spans_checked;
    int              units_seen;
    int              flushes;
    int              triple_runs;

    function new();
      restart();
      errors        = 0;
      spans_checked = 0;
      units_seen    = 0;
      flushes       = 0;
      triple_runs   = 0;
    endfunction

    function void restart();
      mode      = ModeNormal;
      open_cls  = ClsGap;
      tok_begin = '0;
      pos       = '0;
    endfunction

    function bit word_char(logic [CharW-1:0] c);
      return (c >= ChNonAscii) || (c >= ChDigit0 && c <= ChDigit9) ||
             (c >= ChUpperA && c <= ChUpperZ) || (c >= ChLowerA && c <= ChLowerZ) ||
             c == ChCaret || c == ChUnderscore || c == ChBar || c == ChTilde;
    endfunction

    function void add_span(class_e cls, logic [PosW-1:0] s, logic [PosW-1:0] e,
                           logic partial);
      span_t sp;
      sp.cls      = cls;
      sp.from_pos = s;
      sp.to_pos   = e;
      sp.partial  = partial;
      sp.last     = 1'b0;
      run_spans.push_back(sp);
    endfunction

    function void close_tok(class_e cls, logic [PosW-1:0] e);
      add_span(cls, tok_begin, e, 1'b0);
      mode      = ModeNormal;
      open_cls  = ClsGap;
      tok_begin = e;
    endfunction

    // Start a token in the normal mode; whitespace just extends the gap
    function void scan_normal(logic [CharW-1:0] c, logic [PosW-1:0] p);
      if (c == ChTab || c == ChSpace || c == ChNewline) return;
      add_span(ClsGap, tok_begin, p, 1'b0);
      tok_begin = p;
      if (c == ChDquote) begin
        open_cls = ClsString;
        mode     = ModeDq;
      end else if (c == ChSquote) begin
        open_cls = ClsString;
        mode     = ModeSq;
      end else if (c == ChHash) begin
        open_cls = ClsComment;
        mode     = ModeComment;
      end else if (c == ChDollar || c == ChPercent || c == ChAt || c == ChGreater) begin
        open_cls = ClsVariable;
        mode     = ModeVar;
      end else if (c >= ChDigit0 && c <= ChDigit9) begin
        open_cls = ClsNumber;
        mode     = ModeNumber;
      end else if (word_char(c)) begin
        open_cls = ClsBare;
        mode     = ModeWord;
      end else begin
        close_tok(ClsOperator, p + 1'b1);
      end
    endfunction

    // Predict the spans caused by one accepted beat
    function void classify_unit(logic [CharW-1:0] c, logic eot);
      logic [PosW-1:0] p;
      bit              again;
      p     = pos;
      again = 1'b0;
      run_spans.delete();
      units_seen++;
      if (eot) begin
        flushes++;
        add_span(open_cls, tok_begin, p, 1'b1);
        restart();
      end else begin
        case (mode)
          ModeDq: begin
            if (c == ChDquote) close_tok(ClsString, p + 1'b1);
            else if (c == ChBackslash) mode = ModeDqEsc;
          end
          ModeDqEsc: mode = ModeDq;
          ModeSq: begin
            if (c == ChSquote) close_tok(ClsString, p + 1'b1);
            else if (c == ChBackslash) mode = ModeSqEsc;
          end
          ModeSqEsc: mode = ModeSq;
          ModeComment: begin
            if (c == ChNewline) begin
              close_tok(ClsComment, p);
              again = 1'b1;
            end else if (c == ChBackslash) begin
              mode = ModeCommentEsc;
            end
          end
          ModeCommentEsc: mode = ModeComment;
          ModeNumber: begin
            if (!word_char(c)) begin
              close_tok(ClsNumber, p);
              again = 1'b1;
            end
          end
          ModeVar: begin
            if (word_char(c)) begin
              mode = ModeVarName;
            end else begin
              close_tok(ClsVariable, p);
              again = 1'b1;
            end
          end
          ModeVarName: begin
            if (!word_char(c)) begin
              close_tok(ClsVariable, p);
              again = 1'b1;
            end
          end
          ModeWord: begin
            if (c == ChMinus || c == ChColon || c == ChLparen) begin
              close_tok(ClsCall, p);
              again = 1'b1;
            end else if (!word_char(c)) begin
              close_tok(ClsBare, p);
              again = 1'b1;
            end
          end
          ModeNormal: scan_normal(c, p);
          default: begin
            mode = ModeNormal;
            scan_normal(c, p);
          end
        endcase
        if (again) scan_normal(c, p);
        pos = p + 1'b1;
      end
      if (run_spans.size() > 0) run_spans[run_spans.size()-1].last = 1'b1;
      if (run_spans.size() == 3) triple_runs++;
      foreach (run_spans[i]) expected_spans.push_back(run_spans[i]);
    endfunction

    // Compare one span beat with the oldest prediction
    function void check_span(logic [OutDataW-1:0] data, logic partial, logic last);
      span_t want;
      if (expected_spans.size() == 0) begin
        $error("span with no expectation waiting: class %0d start %0d end %0d",
               data[2:0], data[34:3], data[66:35]);
        errors++;
        return;
      end
      want = expected_spans.pop_front();
      spans_checked++;
      if (data[2:0] !== want.cls) begin
        $error("span_class: expected %0d, actual %0d", want.cls, data[2:0]);
        errors++;
      end
      if (data[34:3] !== want.from_pos) begin
        $error("span_start: expected %0d, actual %0d", want.from_pos, data[34:3]);
        errors++;
      end
      if (data[66:35] !== want.to_pos) begin
        $error("span_end: expected %0d, actual %0d", want.to_pos, data[66:35]);
        errors++;
      end
      if (partial !== want.partial) begin
        $error("span_partial: expected %0d, actual %0d", want.partial, partial);
        errors++;
      end
      if (last !== want.last) begin
        $error("last_of_run: expected %0d, actual %0d", want.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return expected_spans.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Signals and block under test
  // --------------------------------------------------------------------------
  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;
  logic                m_axis_tlast;

  span_scoreboard sb;
  int             tx_gap_max;
  int             rx_gap_max;
  int             rx_wait;
  int             rx_long_hold;
  int             items_sent;
  int unsigned    cycles;

  perl_token_classifier i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog: give up if the run hangs
  initial begin
    cycles = 0;
    while (cycles < CyclesLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d spans outstanding", cycles, sb.pending());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Receiver: drop tready for the drawn wait or a long hold, else accept
  initial begin
    m_axis_tready = 1'b0;
    rx_wait       = 0;
    rx_long_hold  = 0;
    forever begin
      @(negedge clk_i);
      if (rx_long_hold > 0) begin
        m_axis_tready <= 1'b0;
        rx_long_hold--;
      end else if (rx_wait > 0) begin
        m_axis_tready <= 1'b0;
        rx_wait--;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Monitor: note accepted code units, then check span beats
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) sb.classify_unit(s_axis_tdata, s_axis_tuser);
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_span(m_axis_tdata, m_axis_tuser, m_axis_tlast);
        rx_wait = $urandom_range(0, rx_gap_max);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Character pickers
  // --------------------------------------------------------------------------
  function automatic logic [CharW-1:0] rand_word();
    case ($urandom_range(0, 4))
      0: return CharW'(ChDigit0 + $urandom_range(0, 9));
      1: return CharW'(ChUpperA + $urandom_range(0, 25));
      2: return CharW'(ChLowerA + $urandom_range(0, 25));
      3: begin
        case ($urandom_range(0, 3))
          0: return ChCaret;
          1: return ChUnderscore;
          2: return ChBar;
          default: return ChTilde;
        endcase
      end
      default: return CharW'(ChNonAscii + $urandom_range(0, 16'hFF7F));
    endcase
  endfunction

  function automatic logic [CharW-1:0] rand_oper();
    string ops;
    ops = "!&*+,-./:;<=?[]{}()\\";
    return {8'h00, ops[$urandom_range(0, ops.len() - 1)]};
  endfunction

  function automatic logic [CharW-1:0] rand_any();
    if ($urandom_range(0, 1) == 0) return CharW'($urandom_range(0, 16'h007F));
    return CharW'($urandom_range(0, 16'hFFFF));
  endfunction

  function automatic logic [CharW-1:0] rand_space();
    case ($urandom_range(0, 2))
      0: return ChTab;
      1: return ChNewline;
      default: return ChSpace;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Sender tasks
  // --------------------------------------------------------------------------
  task automatic send_char(input logic [CharW-1:0] code, input logic eot);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= code;
    s_axis_tuser  <= eot;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic send_text(input string txt);
    for (int i = 0; i < txt.len(); i++) send_char({8'h00, txt[i]}, 1'b0);
  endtask

  // Stop offering and hold until every predicted span has arrived
  task automatic wait_quiet();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // Quoted body: escapes and random units, never the closing quote bare
  task automatic send_quoted(input logic [CharW-1:0] quote);
    logic [CharW-1:0] c;
    send_char(quote, 1'b0);
    repeat ($urandom_range(0, 5)) begin
      if ($urandom_range(0, 3) == 0) begin
        send_char(ChBackslash, 1'b0);
        send_char($urandom_range(0, 1) ? quote : rand_any(), 1'b0);
      end else begin
        c = rand_any();
        send_char((c == quote) ? ChSpace : c, 1'b0);
      end
    end
    send_char(quote, 1'b0);
  endtask

  // One random token, mostly well formed, with some noise and early flushes
  task automatic send_token();
    logic [CharW-1:0] c;
    case ($urandom_range(0, 19))
      0, 1: repeat ($urandom_range(1, 3)) send_char(rand_space(), 1'b0);
      2: send_quoted(ChDquote);
      3: send_quoted(ChSquote);
      4: begin
        send_char(ChHash, 1'b0);
        repeat ($urandom_range(0, 5)) begin
          if ($urandom_range(0, 3) == 0) begin
            send_char(ChBackslash, 1'b0);
            send_char($urandom_range(0, 1) ? ChNewline : rand_any(), 1'b0);
          end else begin
            c = rand_any();
            send_char((c == ChNewline) ? ChSpace : c, 1'b0);
          end
        end
        send_char(ChNewline, 1'b0);
      end
      5: begin
        send_char(CharW'(ChDigit0 + $urandom_range(0, 9)), 1'b0);
        repeat ($urandom_range(0, 3)) send_char(rand_word(), 1'b0);
      end
      6, 7: begin
        case ($urandom_range(0, 3))
          0: send_char(ChDollar, 1'b0);
          1: send_char(ChPercent, 1'b0);
          2: send_char(ChAt, 1'b0);
          default: send_char(ChGreater, 1'b0);
        endcase
        repeat ($urandom_range(0, 4)) send_char(rand_word(), 1'b0);
      end
      8, 9: begin
        repeat ($urandom_range(1, 4)) send_char(rand_word(), 1'b0);
        case ($urandom_range(0, 2))
          0: send_char(ChMinus, 1'b0);
          1: send_char(ChColon, 1'b0);
          default: send_char(ChLparen, 1'b0);
        endcase
      end
      10, 11: begin
        repeat ($urandom_range(1, 4)) send_char(rand_word(), 1'b0);
        send_char($urandom_range(0, 1) ? rand_space() : rand_oper(), 1'b0);
      end
      12, 13: send_char(rand_oper(), 1'b0);
      14, 15: send_char(CharW'($urandom_range(0, 16'hFFFF)), 1'b0);
      16: send_char(CharW'($urandom_range(0, 16'h007F)), 1'b0);
      17: send_char(CharW'($urandom_range(0, 16'hFFFF)), 1'b1);
      default: begin
        // broken token: open something, then flush it
        send_char($urandom_range(0, 1) ? ChDquote : ChHash, 1'b0);
        repeat ($urandom_range(0, 2)) send_char(rand_word(), 1'b0);
        send_char(CharW'($urandom_range(0, 16'hFFFF)), 1'b1);
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    bit hold_done;
    int next_phase;

    sb            = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    tx_gap_max    = 17;
    rx_gap_max    = 17;
    items_sent    = 0;
    hold_done     = 1'b0;
    next_phase    = 0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed text: whitespace, all-ones word unit, call word closed by '(',
    // both quote kinds with escapes, a continued comment, number closed by
    // a zero unit, variables, call words by '-' and ':', flushes mid token
    // and in the normal mode
    send_text(" \t\n");
    send_char(16'hFFFF, 1'b0);
    send_text("(\"\\\"\"'\\''#\\\n\n7");
    send_char(16'h0000, 1'b0);
    send_text("%;>a");
    send_char(CharW'($urandom_range(0, 16'hFFFF)), 1'b1);
    send_text("k-m:");
    send_char(16'h1234, 1'b1);
    wait_quiet();

    // Random text in phases of differing pace
    while (items_sent < TextUnits) begin
      if (items_sent >= next_phase) begin
        case ($urandom_range(0, 3))
          0: begin
            tx_gap_max = 0;
            rx_gap_max = 0;
          end
          1: begin
            tx_gap_max = 17;
            rx_gap_max = 0;
          end
          2: begin
            tx_gap_max = 0;
            rx_gap_max = 17;
          end
          default: begin
            tx_gap_max = 17;
            rx_gap_max = 17;
          end
        endcase
        next_phase = items_sent + 30;
      end
      if (!hold_done && items_sent >= 110) begin
        // Long receiver hold while operators keep coming: fill and stall
        rx_long_hold = 120;
        tx_gap_max   = 0;
        repeat (20) send_char(rand_oper(), 1'b0);
        wait_quiet();
        hold_done = 1'b1;
      end
      send_token();
    end
    wait_quiet();

    $display("Sent %0d code units with %0d end-of-text flushes; %0d spans checked.",
             sb.units_seen, sb.flushes, sb.spans_checked);
    $display("Units yielding three spans: %0d; one long output hold with input stall.",
             sb.triple_runs);
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
